@@ rtl/leb_pkg.sv @@
// Shared types and constants for the line edit buffer.
package leb_pkg;

    localparam int KEY_W  = 8;
    localparam int KIND_W = 2;
    localparam int POS_W  = 7;
    localparam int CHAR_W = 7;

    localparam logic [KEY_W-1:0] KEY_LF         = 8'd10;
    localparam logic [KEY_W-1:0] KEY_CR         = 8'd13;
    localparam logic [KEY_W-1:0] KEY_ESC        = 8'd27;
    localparam logic [KEY_W-1:0] KEY_BS         = 8'd127;
    localparam logic [KEY_W-1:0] KEY_LBRACKET   = 8'h5B;
    localparam logic [KEY_W-1:0] KEY_LEFT       = 8'h44;
    localparam logic [KEY_W-1:0] KEY_RIGHT      = 8'h43;
    localparam logic [KEY_W-1:0] KEY_HOME       = 8'h48;
    localparam logic [KEY_W-1:0] KEY_END        = 8'h46;
    localparam logic [KEY_W-1:0] KEY_DEL3       = 8'h33;
    localparam logic [KEY_W-1:0] KEY_FIRST_PRINT = 8'd32;
    localparam logic [KEY_W-1:0] KEY_LAST_PRINT  = 8'd126;

    localparam logic [CHAR_W-1:0] SPACE_CH = 7'd32;

    localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_END,
        OP_DEL,
        OP_BS,
        OP_PUT,
        OP_ENTER
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
    } t_req;

endpackage

@@ rtl/leb_front.sv @@
// Front end: escape sequence parser that turns key bytes into edit requests.
module leb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_key_valid,
    output logic                  o_key_ready,
    input  logic [leb_pkg::KEY_W-1:0] i_key_byte,
    output logic                  o_req_valid,
    input  logic                  i_req_ready,
    output leb_pkg::t_req         o_req
);
    import leb_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI,
        PH_DEL
    } t_phase;

    t_phase r_phase, n_phase;
    logic   push;
    t_op    op;

    assign o_key_ready = i_req_ready;

    always_comb begin
        n_phase = r_phase;
        push    = 1'b1;
        op      = OP_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (i_key_byte == KEY_ESC) begin
                    n_phase = PH_ESC;
                    push    = 1'b0;
                end else if (i_key_byte == KEY_CR || i_key_byte == KEY_LF) begin
                    op = OP_ENTER;
                end else if (i_key_byte == KEY_BS) begin
                    op = OP_BS;
                end else if (i_key_byte inside {[KEY_FIRST_PRINT:KEY_LAST_PRINT]}) begin
                    op = OP_PUT;
                end
            end
            PH_ESC: begin
                if (i_key_byte == KEY_LBRACKET) begin
                    n_phase = PH_CSI;
                    push    = 1'b0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CSI: begin
                n_phase = PH_IDLE;
                case (i_key_byte)
                    KEY_LEFT:  op = OP_LEFT;
                    KEY_RIGHT: op = OP_RIGHT;
                    KEY_HOME:  op = OP_HOME;
                    KEY_END:   op = OP_END;
                    KEY_DEL3: begin
                        n_phase = PH_DEL;
                        push    = 1'b0;
                    end
                    default:   op = OP_NONE;
                endcase
            end
            PH_DEL: begin
                // any byte completes ESC [ 3
                n_phase = PH_IDLE;
                op      = OP_DEL;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    assign o_req_valid = i_key_valid && push;
    assign o_req.op    = op;
    assign o_req.ch    = i_key_byte[CHAR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_key_valid && i_req_ready) begin
            r_phase <= n_phase;
        end
    end

endmodule

@@ rtl/leb_queue.sv @@
// Two-entry request queue between the parser and the editor.
module leb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  leb_pkg::t_req i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output leb_pkg::t_req o_pop_data
);
    import leb_pkg::*;

    t_req       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/leb_trim.sv @@
// Registered tree that finds the used length of the line (last non-space + 1).
module leb_trim #(
    parameter int LINE_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic [LINE_WIDTH-1:0]               i_nonspace,
    output logic [$clog2(LINE_WIDTH+1)-1:0]     o_used
);
    import leb_pkg::*;

    localparam int UW    = $clog2(LINE_WIDTH + 1);
    localparam int IDX_W = $clog2(LINE_WIDTH);
    localparam int NC    = (LINE_WIDTH + 7) / 8;
    localparam int NG    = (NC + 7) / 8;

    logic             r_l1_any [NC];
    logic [IDX_W-1:0] r_l1_idx [NC];
    logic             n_l1_any [NC];
    logic [IDX_W-1:0] n_l1_idx [NC];
    logic             r_l2_any [NG];
    logic [IDX_W-1:0] r_l2_idx [NG];
    logic             n_l2_any [NG];
    logic [IDX_W-1:0] n_l2_idx [NG];
    logic             l3_any;
    logic [IDX_W-1:0] l3_idx;
    logic [UW-1:0]    r_used;

    // later hits overwrite earlier ones, so the highest index wins
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_l1_any[k] = 1'b0;
            n_l1_idx[k] = '0;
            for (int j = 0; j < 8; j++) begin
                if (k * 8 + j < LINE_WIDTH) begin
                    if (i_nonspace[k * 8 + j]) begin
                        n_l1_any[k] = 1'b1;
                        n_l1_idx[k] = IDX_W'(k * 8 + j);
                    end
                end
            end
        end
        for (int g = 0; g < NG; g++) begin
            n_l2_any[g] = 1'b0;
            n_l2_idx[g] = '0;
            for (int j = 0; j < 8; j++) begin
                if (g * 8 + j < NC) begin
                    if (r_l1_any[g * 8 + j]) begin
                        n_l2_any[g] = 1'b1;
                        n_l2_idx[g] = r_l1_idx[g * 8 + j];
                    end
                end
            end
        end
        l3_any = 1'b0;
        l3_idx = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_l2_any[g]) begin
                l3_any = 1'b1;
                l3_idx = r_l2_idx[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NC; k++) begin
            r_l1_any[k] <= n_l1_any[k];
            r_l1_idx[k] <= n_l1_idx[k];
        end
        for (int g = 0; g < NG; g++) begin
            r_l2_any[g] <= n_l2_any[g];
            r_l2_idx[g] <= n_l2_idx[g];
        end
        r_used <= l3_any ? (UW'(l3_idx) + UW'(1)) : '0;
    end

    assign o_used = r_used;

endmodule

@@ rtl/leb_back.sv @@
// Back end: line store, cursor, edit execution and result output register.
module leb_back #(
    parameter int LINE_WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  leb_pkg::t_req               i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [leb_pkg::KIND_W-1:0]  o_result_kind,
    output logic [leb_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [leb_pkg::CHAR_W-1:0]  o_line_char,
    output logic                        o_last_of_run
);
    import leb_pkg::*;

    localparam int CUR_W = $clog2(LINE_WIDTH + 1);
    // settle count lets the trim tree's l1, l2 and used registers reflect the last store change
    localparam logic [1:0] SETTLE_CYC = 2'd3;

    typedef enum logic [1:0] {
        S_RUN,
        S_SETTLE,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_cnt, n_cnt;
    logic              r_pend_enter, n_pend_enter;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [CUR_W-1:0]  r_remain, n_remain;
    logic [CHAR_W-1:0] r_line [LINE_WIDTH];
    logic [CHAR_W-1:0] n_line [LINE_WIDTH];

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;

    logic                  out_free;
    logic                  del_en;
    logic [CUR_W-1:0]      del_pos;
    logic                  put_en;
    logic [LINE_WIDTH-1:0] nonspace;
    logic [CUR_W-1:0]      used;

    assign out_free    = !r_out_valid || i_res_ready;
    assign o_req_ready = (r_state == S_RUN) && out_free;

    always_comb begin
        for (int i = 0; i < LINE_WIDTH; i++) begin
            nonspace[i] = (r_line[i] != SPACE_CH);
        end
    end

    leb_trim #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_trim (
        .i_clk      (i_clk),
        .i_nonspace (nonspace),
        .o_used     (used)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pend_enter = r_pend_enter;
        n_cursor     = r_cursor;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_kind       = r_kind;
        n_pos        = r_pos;
        n_char       = r_char;
        n_last       = r_last;
        del_en       = 1'b0;
        del_pos      = r_cursor;
        put_en       = 1'b0;

        case (r_state)
            S_RUN: begin
                if (i_req_valid && o_req_ready) begin
                    case (i_req.op)
                        OP_END, OP_ENTER: begin
                            n_state      = S_SETTLE;
                            n_cnt        = SETTLE_CYC;
                            n_pend_enter = (i_req.op == OP_ENTER);
                        end
                        default: begin
                            case (i_req.op)
                                OP_LEFT: begin
                                    if (r_cursor != '0) n_cursor = r_cursor - CUR_W'(1);
                                end
                                OP_RIGHT: begin
                                    if (r_cursor < CUR_W'(LINE_WIDTH - 1))
                                        n_cursor = r_cursor + CUR_W'(1);
                                end
                                OP_HOME: n_cursor = '0;
                                OP_DEL: begin
                                    del_en  = (r_cursor < CUR_W'(LINE_WIDTH));
                                    del_pos = r_cursor;
                                end
                                OP_BS: begin
                                    if (r_cursor != '0) begin
                                        del_en   = 1'b1;
                                        del_pos  = r_cursor - CUR_W'(1);
                                        n_cursor = r_cursor - CUR_W'(1);
                                    end
                                end
                                OP_PUT: begin
                                    if (r_cursor < CUR_W'(LINE_WIDTH)) begin
                                        put_en   = 1'b1;
                                        n_cursor = r_cursor + CUR_W'(1);
                                    end
                                end
                                default: ;
                            endcase
                            n_out_valid = 1'b1;
                            n_kind      = KIND_CURSOR;
                            n_pos       = POS_W'(n_cursor);
                            n_char      = '0;
                            n_last      = 1'b1;
                        end
                    endcase
                end
            end
            S_SETTLE: begin
                if (r_cnt != 2'd0) begin
                    n_cnt = r_cnt - 2'd1;
                end else if (r_pend_enter) begin
                    if (used == '0) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_EMPTY;
                            n_pos       = '0;
                            n_char      = '0;
                            n_last      = 1'b1;
                            n_cursor    = '0;
                            n_state     = S_RUN;
                        end
                    end else begin
                        n_remain = used;
                        n_cursor = '0;
                        n_state  = S_EMIT;
                    end
                end else if (out_free) begin
                    n_cursor    = (used >= CUR_W'(LINE_WIDTH)) ? CUR_W'(LINE_WIDTH - 1) : used;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CURSOR;
                    n_pos       = POS_W'(n_cursor);
                    n_char      = '0;
                    n_last      = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_EMIT: begin
                // shift the line out through cell 0; spaces fill in behind
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CHAR;
                    n_pos       = '0;
                    n_char      = r_line[0];
                    n_last      = (r_remain == CUR_W'(1));
                    del_en      = 1'b1;
                    del_pos     = '0;
                    n_remain    = r_remain - CUR_W'(1);
                    if (r_remain == CUR_W'(1)) n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        for (int i = 0; i < LINE_WIDTH; i++) begin
            n_line[i] = r_line[i];
            if (del_en && CUR_W'(i) >= del_pos) begin
                if (i == LINE_WIDTH - 1) n_line[i] = SPACE_CH;
                else                     n_line[i] = r_line[(i + 1) % LINE_WIDTH];
            end else if (put_en && CUR_W'(i) == r_cursor) begin
                n_line[i] = i_req.ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_cnt        <= 2'd0;
            r_pend_enter <= 1'b0;
            r_cursor     <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < LINE_WIDTH; i++) r_line[i] <= SPACE_CH;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend_enter <= n_pend_enter;
            r_cursor     <= n_cursor;
            r_out_valid  <= n_out_valid;
            for (int i = 0; i < LINE_WIDTH; i++) r_line[i] <= n_line[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_res_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_cursor_pos  = r_pos;
    assign o_line_char   = r_char;
    assign o_last_of_run = r_last;

endmodule

@@ rtl/line_edit_buffer.sv @@
// Line edit buffer: fixed-width single-line editor fed one key byte per request.
//
// Key channel (i_key_valid/o_key_ready/i_key_byte): one raw byte per request.
// A parser tracks ESC [ sequences and posts edit requests into a two-entry
// queue; it keeps taking bytes while the queue has room, so escape prefix
// bytes, which give no result, pass without taking a queue entry.
// Result channel (o_res_valid/i_res_ready): kind, cursor, character and a
// last-of-run flag, held in an output register.
// A cursor or edit key's result passes through the queue and the output
// register, and the editor retires one such key per cycle while the receiver
// takes each result. End (ESC [ F) and Enter first hold the editor in a settle
// state while the registered trailing-space search settles, then End gives
// its cursor result; Enter then streams the trimmed line one character per
// cycle while the receiver keeps up, or gives one empty result for an empty line.
// When the receiver stalls, the output register holds its result, the editor
// stops, and the key channel backs up once the queue is full.
// Reset clears the line to spaces, the cursor to 0 and the parser to idle.
module line_edit_buffer #(
    parameter int LINE_WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_key_valid,
    output logic                        o_key_ready,
    input  logic [leb_pkg::KEY_W-1:0]   i_key_byte,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [leb_pkg::KIND_W-1:0]  o_result_kind,
    output logic [leb_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [leb_pkg::CHAR_W-1:0]  o_line_char,
    output logic                        o_last_of_run
);
    import leb_pkg::*;

    logic fq_valid, fq_ready;
    t_req fq_req;
    logic qb_valid, qb_ready;
    t_req qb_req;

    leb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (i_key_valid),
        .o_key_ready (o_key_ready),
        .i_key_byte  (i_key_byte),
        .o_req_valid (fq_valid),
        .i_req_ready (fq_ready),
        .o_req       (fq_req)
    );

    leb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_req),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_data   (qb_req)
    );

    leb_back #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (qb_valid),
        .o_req_ready   (qb_ready),
        .i_req         (qb_req),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_result_kind (o_result_kind),
        .o_cursor_pos  (o_cursor_pos),
        .o_line_char   (o_line_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule

@@ sim/tb_line_edit_buffer.sv @@
// Self-checking testbench for line_edit_buffer: key stream in, cursor and line results out.
module tb_line_edit_buffer;
    import leb_pkg::*;

    localparam int LINE_W     = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;
    localparam int N_RANDOM   = 500;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_CSI,
        ESC_DEL
    } t_esc_state;

    class line_edit_scoreboard;
        logic [CHAR_W-1:0] text [LINE_W];
        int                caret;
        t_esc_state        esc_state;
        t_result           want_q[$];
        int                errors;

        function new();
            clear_line();
            esc_state = ESC_IDLE;
            errors    = 0;
        endfunction

        function void clear_line();
            foreach (text[i]) text[i] = SPACE_CH;
            caret = 0;
        endfunction

        function int used_len();
            int n;
            n = LINE_W;
            while (n > 0 && text[n-1] == SPACE_CH) n--;
            return n;
        endfunction

        // drop one cell, pull the tail left, space into the last cell
        function void shift_out(int pos);
            for (int i = pos; i + 1 < LINE_W; i++) text[i] = text[i+1];
            text[LINE_W-1] = SPACE_CH;
        endfunction

        function void queue_result(logic [KIND_W-1:0] kind, int pos,
                                   logic [CHAR_W-1:0] ch, logic last);
            t_result r;
            r.kind = kind;
            r.pos  = pos[POS_W-1:0];
            r.ch   = ch;
            r.last = last;
            want_q.insert(want_q.size(), r);
        endfunction

        // predict the results of one accepted key request
        function void apply_key(logic [KEY_W-1:0] b);
            int n;
            case (esc_state)
                ESC_SEEN: begin
                    if (b == KEY_LBRACKET) begin
                        esc_state = ESC_CSI;
                        return;
                    end
                    esc_state = ESC_IDLE;
                end
                ESC_CSI: begin
                    if (b == KEY_DEL3) begin
                        esc_state = ESC_DEL;
                        return;
                    end
                    esc_state = ESC_IDLE;
                    case (b)
                        KEY_LEFT:  if (caret > 0) caret--;
                        KEY_RIGHT: if (caret < LINE_W - 1) caret++;
                        KEY_HOME:  caret = 0;
                        KEY_END: begin
                            n     = used_len();
                            caret = (n >= LINE_W) ? LINE_W - 1 : n;
                        end
                        default: ;
                    endcase
                end
                ESC_DEL: begin
                    esc_state = ESC_IDLE;
                    if (caret < LINE_W) shift_out(caret);
                end
                default: begin
                    if (b == KEY_ESC) begin
                        esc_state = ESC_SEEN;
                        return;
                    end
                    if (b == KEY_CR || b == KEY_LF) begin
                        n = used_len();
                        if (n == 0) begin
                            queue_result(KIND_EMPTY, 0, '0, 1'b1);
                        end else begin
                            for (int i = 0; i < n; i++)
                                queue_result(KIND_CHAR, 0, text[i], i == n - 1);
                        end
                        clear_line();
                        return;
                    end
                    if (b == KEY_BS) begin
                        if (caret > 0) begin
                            shift_out(caret - 1);
                            caret--;
                        end
                    end else if (b >= KEY_FIRST_PRINT && b <= KEY_LAST_PRINT) begin
                        if (caret < LINE_W) begin
                            text[caret] = b[CHAR_W-1:0];
                            caret++;
                        end
                    end
                end
            endcase
            queue_result(KIND_CURSOR, caret, '0, 1'b1);
        endfunction

        function string show(t_result r);
            return $sformatf("kind=%0d pos=%0d ch=%0d last=%0b",
                             r.kind, r.pos, r.ch, r.last);
        endfunction

        function void flag(string what, t_result want, t_result got);
            errors++;
            if (errors <= 10)
                $display("%0t %s: expected %s, got %s",
                         $time, what, show(want), show(got));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (want_q.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = want_q.pop_front();
            if (got.kind !== want.kind || got.pos !== want.pos ||
                got.ch !== want.ch || got.last !== want.last)
                flag("result mismatch", want, got);
        endfunction

        function int outstanding();
            return want_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                key_valid;
    logic [KEY_W-1:0]    key_byte;
    logic                res_ready;
    logic                o_key_ready;
    logic                o_res_valid;
    logic [KIND_W-1:0]   o_result_kind;
    logic [POS_W-1:0]    o_cursor_pos;
    logic [CHAR_W-1:0]   o_line_char;
    logic                o_last_of_run;

    line_edit_scoreboard edit_sb;
    int                  keys_sent;
    int                  results_seen;
    int                  idle_cycles;
    bit                  quick_keys;

    line_edit_buffer #(
        .LINE_WIDTH(LINE_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_valid   (key_valid),
        .o_key_ready   (o_key_ready),
        .i_key_byte    (key_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (res_ready),
        .o_result_kind (o_result_kind),
        .o_cursor_pos  (o_cursor_pos),
        .o_line_char   (o_line_char),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_key(input logic [KEY_W-1:0] b);
        int gap;
        gap = quick_keys ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            key_valid <= 1'b0;
            @(negedge i_clk);
        end
        key_valid <= 1'b1;
        key_byte  <= b;
        @(posedge i_clk);
        while (!o_key_ready) @(posedge i_clk);
        edit_sb.apply_key(b);
        keys_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_csi(input logic [KEY_W-1:0] b);
        send_key(KEY_ESC);
        send_key(KEY_LBRACKET);
        send_key(b);
    endtask

    task automatic send_random_session();
        int pick;
        int n;
        pick       = $urandom_range(0, 99);
        quick_keys = ($urandom_range(0, 4) == 0);
        if (pick < 50) begin
            n = $urandom_range(1, 12);
            repeat (n) send_key(KEY_W'($urandom_range(KEY_FIRST_PRINT, KEY_LAST_PRINT)));
        end else if (pick < 54) begin
            // type near or past the right edge, then poke the line
            n = $urandom_range(60, 68);
            repeat (n) send_key(KEY_W'($urandom_range(KEY_FIRST_PRINT, KEY_LAST_PRINT)));
            case ($urandom_range(0, 2))
                0: send_csi(KEY_END);
                1: begin
                    send_csi(KEY_DEL3);
                    send_key(KEY_W'($urandom_range(0, 255)));
                end
                default: send_key(KEY_BS);
            endcase
        end else if (pick < 70) begin
            case ($urandom_range(0, 5))
                0: send_csi(KEY_LEFT);
                1: send_csi(KEY_RIGHT);
                2: send_csi(KEY_HOME);
                3: send_csi(KEY_END);
                4: begin
                    send_csi(KEY_DEL3);
                    send_key(KEY_W'($urandom_range(0, 255)));
                end
                default: send_csi(KEY_W'($urandom_range(0, 255)));
            endcase
        end else if (pick < 78) begin
            n = $urandom_range(1, 4);
            repeat (n) send_key(KEY_BS);
        end else if (pick < 86) begin
            send_key($urandom_range(0, 1) ? KEY_CR : KEY_LF);
        end else begin
            case ($urandom_range(0, 3))
                0: send_key(KEY_W'($urandom_range(0, 255)));
                1: send_key(KEY_W'($urandom_range(128, 255)));
                2: begin
                    send_key(KEY_ESC);
                    send_key($urandom_range(0, 1) ? KEY_CR : KEY_W'($urandom_range(0, 255)));
                end
                default: begin
                    send_key(KEY_ESC);
                    send_key(KEY_LBRACKET);
                    send_key($urandom_range(0, 1) ? KEY_LF : KEY_W'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int  stall;
        bit  held;
        t_result got;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 150) begin
                held      = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            stall = (results_seen % 64 < 16) ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                res_ready <= 1'b0;
                @(negedge i_clk);
            end
            res_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_res_valid) @(posedge i_clk);
            got.kind = o_result_kind;
            got.pos  = o_cursor_pos;
            got.ch   = o_line_char;
            got.last = o_last_of_run;
            edit_sb.check_result(got);
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((key_valid && o_key_ready) || (o_res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] opening[$];
        edit_sb      = new();
        keys_sent    = 0;
        results_seen = 0;
        idle_cycles  = 0;
        quick_keys   = 1'b0;
        i_rst_n      = 1'b0;
        key_valid    = 1'b0;
        key_byte     = '0;
        res_ready    = 1'b0;

        // backspace at home, ignored bytes, the printable extremes, each
        // cursor move, delete, unknown final byte, Enter swallowed by a
        // sequence, and Enter twice on an empty line
        opening = '{KEY_BS, 8'h00, 8'hFF, KEY_FIRST_PRINT, KEY_LAST_PRINT,
                    KEY_ESC, KEY_LBRACKET, KEY_LEFT,
                    KEY_ESC, KEY_LBRACKET, KEY_HOME,
                    KEY_ESC, KEY_LBRACKET, KEY_RIGHT,
                    KEY_ESC, KEY_LBRACKET, KEY_DEL3, 8'hFF,
                    KEY_ESC, KEY_LBRACKET, KEY_END,
                    KEY_ESC, KEY_LBRACKET, 8'h71,
                    KEY_ESC, KEY_CR,
                    KEY_BS, KEY_CR, KEY_LF};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening[i]) send_key(opening[i]);

        while (keys_sent < opening.size() + N_RANDOM) send_random_session();
        quick_keys = 1'b0;
        send_key(KEY_CR);
        key_valid <= 1'b0;

        while (edit_sb.outstanding() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (edit_sb.errors == 0 && edit_sb.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ line_edit_buffer.f @@
rtl/leb_pkg.sv
rtl/leb_front.sv
rtl/leb_queue.sv
rtl/leb_trim.sv
rtl/leb_back.sv
rtl/line_edit_buffer.sv
sim/tb_line_edit_buffer.sv
